@@ rtl/spc_pkg.sv @@
package spc_pkg;

	localparam int CANVAS_SIZE = 1024;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_KIND = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SIZE_W     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SIZE_H     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_THICKNESS  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR      = 3'd7;

	typedef enum logic [1:0] {
		SHAPE_FILL_RECT   = 2'd0,
		SHAPE_STROKE_RECT = 2'd1,
		SHAPE_DISC        = 2'd2,
		SHAPE_RING        = 2'd3
	} shape_kind_t;

	typedef struct packed {
		shape_kind_t        kind;
		logic signed [11:0] origin_x;
		logic signed [11:0] origin_y;
		logic [10:0]        size_w;
		logic [10:0]        size_h;
		logic [10:0]        radius;
		logic [10:0]        thick;
		logic [7:0]         color;
	} cfg_t;

	// Per-pixel operands of the outer (a) and inner (b) circle tests.
	typedef struct packed {
		logic        hit;
		logic        use_inner;
		logic [9:0]  px;
		logic [9:0]  py;
		logic        ok_a;
		logic [11:0] dx_a;
		logic [11:0] dy_a;
		logic [10:0] r_a;
		logic        ok_b;
		logic [11:0] dx_b;
		logic [11:0] dy_b;
		logic [10:0] r_b;
	} geom_t;

	typedef struct packed {
		logic        ok;
		logic [11:0] dx;
		logic [11:0] dy;
	} box_t;

	// Box membership and distance to the nearest corner center. Outside the
	// corner zones the distance on that axis is zero, which always passes the circle test.
	function automatic box_t round_box(input logic signed [13:0] lx,
			input logic signed [13:0] ly, input logic signed [13:0] w,
			input logic signed [13:0] h, input logic signed [13:0] r);
		box_t b;
		logic signed [13:0] ex;
		logic signed [13:0] ey;
		ex = w - r;
		ey = h - r;
		b.ok = (lx >= 14'sd0) && (ly >= 14'sd0) && (lx < w) && (ly < h);
		priority if (lx < r) begin
			b.dx = 12'(r - 14'sd1 - lx);
		end else if (lx >= ex) begin
			b.dx = 12'(lx - ex);
		end else begin
			b.dx = '0;
		end
		priority if (ly < r) begin
			b.dy = 12'(r - 14'sd1 - ly);
		end else if (ly >= ey) begin
			b.dy = 12'(ly - ey);
		end else begin
			b.dy = '0;
		end
		return b;
	endfunction

	function automatic logic [11:0] mag12(input logic signed [12:0] v);
		return v[12] ? 12'(-v) : 12'(v);
	endfunction

endpackage

@@ rtl/spc_cfg_regs.sv @@
module spc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [spc_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]   wr_data,
	output spc_pkg::cfg_t                    cfg
);
	import spc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SHAPE_KIND: cfg_q.kind     <= shape_kind_t'(wr_data[1:0]);
				REG_ORIGIN_X:   cfg_q.origin_x <= $signed(wr_data[11:0]);
				REG_ORIGIN_Y:   cfg_q.origin_y <= $signed(wr_data[11:0]);
				REG_SIZE_W:     cfg_q.size_w   <= wr_data[10:0];
				REG_SIZE_H:     cfg_q.size_h   <= wr_data[10:0];
				REG_RADIUS:     cfg_q.radius   <= wr_data[10:0];
				REG_THICKNESS:  cfg_q.thick    <= wr_data[10:0];
				REG_COLOR:      cfg_q.color    <= wr_data[7:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/spc_geom.sv @@
module spc_geom (
	input  logic           clk,
	input  logic           arst_n,
	input  spc_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [9:0]     in_x,
	input  logic [9:0]     in_y,
	output logic           out_valid,
	input  logic           out_ready,
	output spc_pkg::geom_t out_geom
);
	import spc_pkg::*;

	logic               v_s1;
	logic               v_s2;
	logic               ready_s1;
	logic               ready_s2;
	logic signed [12:0] lx_s1;
	logic signed [12:0] ly_s1;
	logic [9:0]         rc_s1;
	logic [9:0]         px_s1;
	logic [9:0]         py_s1;
	logic               on_s1;
	geom_t              g_s2;

	logic signed [12:0] lx_c;
	logic signed [12:0] ly_c;
	logic [9:0]         lim_c;
	logic [9:0]         rc_c;
	logic               on_c;

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Stage 1: shape-local coordinates and the clamped corner radius.
	assign lx_c  = $signed({3'b000, in_x}) - $signed({cfg.origin_x[11], cfg.origin_x});
	assign ly_c  = $signed({3'b000, in_y}) - $signed({cfg.origin_y[11], cfg.origin_y});
	assign lim_c = (cfg.size_w[10:1] < cfg.size_h[10:1]) ? cfg.size_w[10:1]
		: cfg.size_h[10:1];
	assign rc_c  = (cfg.radius > {1'b0, lim_c}) ? lim_c : cfg.radius[9:0];
	assign on_c  = ({3'b000, in_x} < 13'(CANVAS_SIZE)) && ({3'b000, in_y} < 13'(CANVAS_SIZE));

	// Stage 2: box tests and distance operands for both circle tests.
	logic signed [13:0] lx14;
	logic signed [13:0] ly14;
	logic signed [13:0] w14;
	logic signed [13:0] h14;
	logic signed [13:0] t14;
	logic signed [13:0] rc14;
	logic [10:0]        ri_c;
	box_t               box_a;
	box_t               box_b;
	geom_t              g_c;

	assign lx14 = $signed({lx_s1[12], lx_s1});
	assign ly14 = $signed({ly_s1[12], ly_s1});
	assign w14  = $signed({3'b000, cfg.size_w});
	assign h14  = $signed({3'b000, cfg.size_h});
	assign t14  = $signed({3'b000, cfg.thick});
	assign rc14 = $signed({4'b0000, rc_s1});
	assign ri_c = ({1'b0, rc_s1} > cfg.thick) ? ({1'b0, rc_s1} - cfg.thick) : '0;

	assign box_a = round_box(lx14, ly14, w14, h14, rc14);
	assign box_b = round_box(lx14 - t14, ly14 - t14, w14 - (t14 <<< 1), h14 - (t14 <<< 1),
		$signed({3'b000, ri_c}));

	always_comb begin
		g_c.hit = on_s1;
		g_c.px  = px_s1;
		g_c.py  = py_s1;
		unique case (cfg.kind)
			SHAPE_FILL_RECT, SHAPE_STROKE_RECT: begin
				g_c.use_inner = (cfg.kind == SHAPE_STROKE_RECT);
				g_c.ok_a = box_a.ok;
				g_c.dx_a = box_a.dx;
				g_c.dy_a = box_a.dy;
				g_c.r_a  = {1'b0, rc_s1};
				g_c.ok_b = box_b.ok;
				g_c.dx_b = box_b.dx;
				g_c.dy_b = box_b.dy;
				g_c.r_b  = ri_c;
			end
			SHAPE_DISC, SHAPE_RING: begin
				g_c.use_inner = (cfg.kind == SHAPE_RING);
				g_c.ok_a = 1'b1;
				g_c.dx_a = mag12(lx_s1);
				g_c.dy_a = mag12(ly_s1);
				g_c.r_a  = cfg.radius;
				g_c.ok_b = 1'b1;
				g_c.dx_b = mag12(lx_s1);
				g_c.dy_b = mag12(ly_s1);
				g_c.r_b  = cfg.thick;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			lx_s1 <= lx_c;
			ly_s1 <= ly_c;
			rc_s1 <= rc_c;
			px_s1 <= in_x;
			py_s1 <= in_y;
			on_s1 <= on_c;
		end
		if (ready_s2 && v_s1) begin
			g_s2 <= g_c;
		end
	end

	assign out_valid = v_s2;
	assign out_geom  = g_s2;

endmodule

@@ rtl/spc_dist.sv @@
module spc_dist (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     color,
	input  logic           in_valid,
	output logic           in_ready,
	input  spc_pkg::geom_t in_geom,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_covered,
	output logic [9:0]     out_x,
	output logic [9:0]     out_y,
	output logic [7:0]     out_color
);
	import spc_pkg::*;

	logic        v_s3;
	logic        v_s4;
	logic        ready_s3;
	logic        ready_s4;

	logic [23:0] sqx_a_s3;
	logic [23:0] sqy_a_s3;
	logic [21:0] rsq_a_s3;
	logic [10:0] r_a_s3;
	logic        ok_a_s3;
	logic [23:0] sqx_b_s3;
	logic [23:0] sqy_b_s3;
	logic [21:0] rsq_b_s3;
	logic [10:0] r_b_s3;
	logic        ok_b_s3;
	logic        hit_s3;
	logic        use_inner_s3;
	logic [9:0]  px_s3;
	logic [9:0]  py_s3;

	logic        covered_s4;
	logic [9:0]  px_s4;
	logic [9:0]  py_s4;
	logic [7:0]  color_s4;

	logic [24:0] sum_a;
	logic [24:0] sum_b;
	logic [21:0] lim_a;
	logic [21:0] lim_b;
	logic        in_a;
	logic        in_b;
	logic        covered_c;

	assign ready_s4 = !v_s4 || out_ready;
	assign ready_s3 = !v_s3 || ready_s4;
	assign in_ready = ready_s3;

	// Stage 4: d <= r*r + r is the integer form of d <= (r + 0.5)^2.
	assign sum_a = {1'b0, sqx_a_s3} + {1'b0, sqy_a_s3};
	assign sum_b = {1'b0, sqx_b_s3} + {1'b0, sqy_b_s3};
	assign lim_a = rsq_a_s3 + {11'b0, r_a_s3};
	assign lim_b = rsq_b_s3 + {11'b0, r_b_s3};
	assign in_a  = ok_a_s3 && (sum_a <= {3'b000, lim_a});
	assign in_b  = ok_b_s3 && (sum_b <= {3'b000, lim_b});
	assign covered_c = hit_s3 && in_a && !(use_inner_s3 && in_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				v_s3 <= in_valid;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			sqx_a_s3     <= in_geom.dx_a * in_geom.dx_a;
			sqy_a_s3     <= in_geom.dy_a * in_geom.dy_a;
			rsq_a_s3     <= in_geom.r_a * in_geom.r_a;
			r_a_s3       <= in_geom.r_a;
			ok_a_s3      <= in_geom.ok_a;
			sqx_b_s3     <= in_geom.dx_b * in_geom.dx_b;
			sqy_b_s3     <= in_geom.dy_b * in_geom.dy_b;
			rsq_b_s3     <= in_geom.r_b * in_geom.r_b;
			r_b_s3       <= in_geom.r_b;
			ok_b_s3      <= in_geom.ok_b;
			hit_s3       <= in_geom.hit;
			use_inner_s3 <= in_geom.use_inner;
			px_s3        <= in_geom.px;
			py_s3        <= in_geom.py;
		end
		if (ready_s4 && v_s3) begin
			covered_s4 <= covered_c;
			px_s4      <= px_s3;
			py_s4      <= py_s3;
			color_s4   <= covered_c ? color : 8'd0;
		end
	end

	assign out_valid   = v_s4;
	assign out_covered = covered_s4;
	assign out_x       = px_s4;
	assign out_y       = py_s4;
	assign out_color   = color_s4;

endmodule

@@ rtl/shape_pixel_coverage_unit.sv @@
// Pixel coverage unit for one configured shape: filled or stroked rounded
// rectangle, disc, or ring. Each input transaction carries a canvas pixel and
// yields exactly one output transaction with the coverage flag, the pixel
// passed through, and the color to write (zero when not covered). The unit
// accepts one pixel per clock while the output is not stalled, through its
// four pipeline stages: local coordinates and corner clamp, box tests and
// corner distances, the squaring multipliers, and the final add and compare.
// Stalls on the output propagate stage by stage, so empty stages keep filling
// while a result waits. Configuration registers may be written only while no
// pixel is in flight; cfg_ready is always high.
module shape_pixel_coverage_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [spc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,  // pixel_x, pixel_y, zero fill
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata   // covered, out_x, out_y, out_color, zero fill
);
	import spc_pkg::*;

	cfg_t       cfg;
	geom_t      geom;
	logic       geom_valid;
	logic       geom_ready;
	logic       covered;
	logic [9:0] out_x;
	logic [9:0] out_y;
	logic [7:0] out_color;

	assign cfg_ready = 1'b1;

	spc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	spc_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_x      (s_tdata[9:0]),
		.in_y      (s_tdata[19:10]),
		.out_valid (geom_valid),
		.out_ready (geom_ready),
		.out_geom  (geom)
	);

	spc_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.color       (cfg.color),
		.in_valid    (geom_valid),
		.in_ready    (geom_ready),
		.in_geom     (geom),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_covered (covered),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_color   (out_color)
	);

	assign m_tdata = {3'b000, out_color, out_y, out_x, covered};

endmodule

@@ bench/tb_shape_pixel_coverage_unit.sv @@
`timescale 1ns / 100ps

module tb_shape_pixel_coverage_unit;
	import spc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		bit         covered;
		bit [9:0]   x;
		bit [9:0]   y;
		bit [7:0]   color;
	} pixel_verdict_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [23:0]             s_tdata;  // pixel_x, pixel_y, zero fill
	logic                    m_tvalid;
	logic                    m_tready;
	logic [31:0]             m_tdata;  // covered, out_x, out_y, out_color, zero fill

	// Shadow copy of the shape registers.
	shape_kind_t cur_kind;
	longint      cur_ox;
	longint      cur_oy;
	longint      cur_w;
	longint      cur_h;
	longint      cur_r;
	longint      cur_t;
	logic [7:0]  cur_color;

	pixel_verdict_t pending_verdicts[$];
	int errors;
	int cycle_count;
	int hold_request;
	bit source_steady;
	bit sink_steady;

	shape_pixel_coverage_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The test passes when d <= r*r + r, the integer form of d <= (r + 0.5)^2.
	function automatic bit in_disc(longint dx, longint dy, longint r);
		return dx * dx + dy * dy <= r * r + r;
	endfunction

	function automatic bit in_rounded_box(longint lx, longint ly, longint w, longint h,
			longint r);
		longint kx;
		longint ky;
		if (lx < 0 || ly < 0 || lx >= w || ly >= h)
			return 1'b0;
		if (r <= 0)
			return 1'b1;
		kx = (lx < r) ? r - 1 : ((lx >= w - r) ? w - r : lx);
		ky = (ly < r) ? r - 1 : ((ly >= h - r) ? h - r : ly);
		if (kx == lx || ky == ly)
			return 1'b1;
		return in_disc(lx - kx, ly - ky, r);
	endfunction

	function automatic longint corner_radius();
		longint lim;
		longint r;
		lim = (cur_w / 2 < cur_h / 2) ? cur_w / 2 : cur_h / 2;
		r = cur_r;
		if (r > lim)
			r = lim;
		if (r < 0)
			r = 0;
		return r;
	endfunction

	function automatic bit shape_covers(longint px, longint py);
		longint lx;
		longint ly;
		longint r;
		longint ri;
		lx = px - cur_ox;
		ly = py - cur_oy;
		case (cur_kind)
			SHAPE_FILL_RECT: begin
				return in_rounded_box(lx, ly, cur_w, cur_h, corner_radius());
			end
			SHAPE_STROKE_RECT: begin
				r = corner_radius();
				if (!in_rounded_box(lx, ly, cur_w, cur_h, r))
					return 1'b0;
				ri = (r - cur_t > 0) ? r - cur_t : 0;
				// A pixel inside the inset box falls in the hole of the stroke.
				if (lx >= cur_t && ly >= cur_t && lx < cur_w - cur_t && ly < cur_h - cur_t &&
						in_rounded_box(lx - cur_t, ly - cur_t, cur_w - 2 * cur_t,
						cur_h - 2 * cur_t, ri))
					return 1'b0;
				return 1'b1;
			end
			SHAPE_DISC: begin
				return in_disc(lx, ly, cur_r);
			end
			default: begin
				return in_disc(lx, ly, cur_r) && !in_disc(lx, ly, cur_t);
			end
		endcase
	endfunction

	function automatic pixel_verdict_t predict_verdict(bit [9:0] px, bit [9:0] py);
		pixel_verdict_t v;
		v.covered = 1'b0;
		if (px < CANVAS_SIZE && py < CANVAS_SIZE)
			v.covered = shape_covers(longint'(px), longint'(py));
		v.x = px;
		v.y = py;
		v.color = v.covered ? cur_color : 8'd0;
		return v;
	endfunction

	function automatic void apply_register(logic [CFG_INDEX_W-1:0] index,
			logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_SHAPE_KIND: cur_kind = shape_kind_t'(data[1:0]);
			REG_ORIGIN_X:   cur_ox = longint'($signed(data));
			REG_ORIGIN_Y:   cur_oy = longint'($signed(data));
			REG_SIZE_W:     cur_w = longint'(data[10:0]);
			REG_SIZE_H:     cur_h = longint'(data[10:0]);
			REG_RADIUS:     cur_r = longint'(data[10:0]);
			REG_THICKNESS:  cur_t = longint'(data[10:0]);
			REG_COLOR:      cur_color = data[7:0];
			default: ;
		endcase
	endfunction

	// Leaves cfg_valid high so back-to-back writes need no gap.
	task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(index, data);
	endtask

	task automatic set_shape(int kind, int ox, int oy, int w, int h, int r, int t, int col);
		cfg_write(REG_SHAPE_KIND, 12'(kind));
		cfg_write(REG_ORIGIN_X, 12'(ox));
		cfg_write(REG_ORIGIN_Y, 12'(oy));
		cfg_write(REG_SIZE_W, 12'(w));
		cfg_write(REG_SIZE_H, 12'(h));
		cfg_write(REG_RADIUS, 12'(r));
		cfg_write(REG_THICKNESS, 12'(t));
		cfg_write(REG_COLOR, 12'(col));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Leaves s_tvalid high so consecutive pixels can go out on every clock while s_tready is high.
	task automatic send_pixel(int x, int y);
		bit [9:0] px;
		bit [9:0] py;
		px = 10'(x);
		py = 10'(y);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, py, px};
		do @(posedge clk); while (!s_tready);
		pending_verdicts.insert(pending_verdicts.size(), predict_verdict(px, py));
	endtask

	task automatic source_gap();
		if (!source_steady && $urandom_range(0, 99) < 4) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic send_near_pixel();
		int x;
		int y;
		if ($urandom_range(0, 4) == 0) begin
			x = $urandom_range(0, 1023);
			y = $urandom_range(0, 1023);
		end else if (cur_kind == SHAPE_FILL_RECT || cur_kind == SHAPE_STROKE_RECT) begin
			x = int'(cur_ox) - 4 + $urandom_range(0, int'(cur_w) + 8);
			y = int'(cur_oy) - 4 + $urandom_range(0, int'(cur_h) + 8);
		end else begin
			x = int'(cur_ox - cur_r) - 4 + $urandom_range(0, int'(2 * cur_r) + 8);
			y = int'(cur_oy - cur_r) - 4 + $urandom_range(0, int'(2 * cur_r) + 8);
		end
		if (x < 0 || x > 1023)
			x = $urandom_range(0, 1023);
		if (y < 0 || y > 1023)
			y = $urandom_range(0, 1023);
		source_gap();
		send_pixel(x, y);
	endtask

	task automatic pick_random_shape();
		int ox;
		int oy;
		int w;
		int h;
		int r;
		int t;
		int sel;
		ox = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1100) - 40 : $urandom_range(0, 4095);
		oy = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1100) - 40 : $urandom_range(0, 4095);
		w = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 200) : $urandom_range(0, 4095);
		h = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 200) : $urandom_range(0, 4095);
		r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 150) : $urandom_range(0, 4095);
		sel = $urandom_range(0, 9);
		if (sel < 2)
			t = 0;
		else if (sel < 8)
			t = $urandom_range(0, (r & 12'h7FF) + 4);
		else
			t = $urandom_range(0, 4095);
		set_shape($urandom_range(0, 3), ox, oy, w, h, r, t, $urandom_range(0, 255));
	endtask

	task automatic run_random_phase(int count);
		pick_random_shape();
		for (int i = 0; i < count; i++) begin
			// Now and then the source stops until the pipeline is empty.
			if (i == count / 2 && $urandom_range(0, 3) == 0)
				drain_results();
			send_near_pixel();
		end
		drain_results();
	endtask

	task automatic test_reset_state();
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		drain_results();
	endtask

	task automatic test_fill_rect();
		set_shape(SHAPE_FILL_RECT, 10, 20, 50, 30, 2047, 0, 8'hA5);
		send_pixel(10, 20);
		send_pixel(35, 35);
		send_pixel(59, 49);
		send_pixel(11, 27);
		drain_results();
	endtask

	task automatic test_stroke_rect();
		set_shape(SHAPE_STROKE_RECT, 100, 100, 40, 40, 8, 0, 8'h3C);
		send_pixel(100, 120);
		send_pixel(120, 120);
		drain_results();
		set_shape(SHAPE_STROKE_RECT, 100, 100, 40, 40, 8, 3, 8'h3C);
		send_pixel(101, 120);
		send_pixel(120, 120);
		drain_results();
		// A stroke of half the size or more leaves no hole.
		set_shape(SHAPE_STROKE_RECT, 100, 100, 40, 40, 8, 20, 8'hC3);
		send_pixel(120, 120);
		drain_results();
	endtask

	task automatic test_disc_and_ring();
		set_shape(SHAPE_DISC, 512, 512, 0, 0, 1023, 0, 8'h5A);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		drain_results();
		set_shape(SHAPE_DISC, 512, 512, 0, 0, 0, 0, 8'h5A);
		send_pixel(512, 512);
		drain_results();
		set_shape(SHAPE_RING, 512, 512, 0, 0, 50, 50, 8'h77);
		send_pixel(512, 562);
		drain_results();
		set_shape(SHAPE_RING, 512, 512, 0, 0, 50, 20, 8'h77);
		send_pixel(512, 562);
		send_pixel(512, 512);
		drain_results();
	endtask

	task automatic test_register_extremes();
		set_shape(SHAPE_FILL_RECT, -1024, -1024, 4095, 4095, 4095, 4095, 255);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		drain_results();
		set_shape(SHAPE_RING, 2047, 2047, 0, 0, 2047, 0, 255);
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		drain_results();
	endtask

	task automatic test_random_shapes();
		for (int p = 0; p < 12; p++)
			run_random_phase(60);
	endtask

	task automatic test_backpressure();
		pick_random_shape();
		// The sink stops long enough for the pipeline to fill and stall the source.
		hold_request = 300;
		repeat (40) send_near_pixel();
		drain_results();
		repeat (20) send_near_pixel();
		drain_results();
	endtask

	task automatic test_steady_stream();
		source_steady = 1'b1;
		sink_steady = 1'b1;
		run_random_phase(120);
		source_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				repeat (hold_request) begin
					m_tready <= 1'b0;
					@(negedge clk);
				end
				hold_request = 0;
			end
			if (sink_steady)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= 7);
		end
	end

	initial begin
		pixel_verdict_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected result transaction: %h", m_tdata);
					errors++;
				end else begin
					want = pending_verdicts.pop_front();
					if (m_tdata[0] !== want.covered) begin
						$error("covered: expected %0d, got %0d", want.covered, m_tdata[0]);
						errors++;
					end
					if (m_tdata[10:1] !== want.x) begin
						$error("out_x: expected %0d, got %0d", want.x, m_tdata[10:1]);
						errors++;
					end
					if (m_tdata[20:11] !== want.y) begin
						$error("out_y: expected %0d, got %0d", want.y, m_tdata[20:11]);
						errors++;
					end
					if (m_tdata[28:21] !== want.color) begin
						$error("out_color: expected %0d, got %0d", want.color, m_tdata[28:21]);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		errors = 0;
		hold_request = 0;
		source_steady = 1'b0;
		sink_steady = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cur_kind = SHAPE_FILL_RECT;
		cur_ox = 0;
		cur_oy = 0;
		cur_w = 0;
		cur_h = 0;
		cur_r = 0;
		cur_t = 0;
		cur_color = 8'd0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_fill_rect();
		test_stroke_rect();
		test_disc_and_ring();
		test_register_extremes();
		test_random_shapes();
		test_backpressure();
		test_steady_stream();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
